### rtl/signed_int_to_decimal_text_top_defines.svh
// Assertion macros for the signed integer to decimal text block.
// Used by the top level; relies on clk and rst_n in the including scope.
`ifndef SIGNED_INT_TO_DECIMAL_TEXT_TOP_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_TEXT_TOP_DEFINES_SVH

// Condition holds in the same cycle as its trigger
`define SIDT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition holds in the cycle after its trigger
`define SIDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sidt_pkg.sv
// Shared types and constants for the signed integer to decimal text block.
// No dependencies.
`timescale 1ns / 1ps

package sidt_pkg;

    // Character field width and ASCII codes (6 bits kept)
    localparam int CHAR_W = 6;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // Double-dabble digit correction
    localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD   = 4'd3;

    // Top-level sequencer
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } sidt_state_t;

    // Character emitter sequencer
    typedef enum logic [4:0] {
        EM_IDLE  = 5'b00001,
        EM_SKIP  = 5'b00010,
        EM_SIGN  = 5'b00100,
        EM_DIGIT = 5'b01000,
        EM_DRAIN = 5'b10000
    } sidt_emit_state_t;

    // Control from the sequencer to the emitter
    typedef struct packed {
        logic start;
        logic neg;
    } sidt_emit_ctl_t;

    // Status back from the emitter
    typedef struct packed {
        logic busy;
        logic done;
    } sidt_emit_stat_t;

endpackage

### rtl/sidt_dabble.sv
// Iterative binary to BCD converter (shift and add-3, one bit per cycle).
// Depends on sidt_pkg.
`timescale 1ns / 1ps

module sidt_dabble
    import sidt_pkg::*;
#(
    parameter int INT_WIDTH  = 32,
    parameter int NUM_DIGITS = 10
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [INT_WIDTH-1:0]      mag,
    output logic [NUM_DIGITS*4-1:0]   bcd,
    output logic                      done
);

    localparam int CNT_W = $clog2(INT_WIDTH + 1);
    localparam int BCD_W = NUM_DIGITS * 4;

    logic [INT_WIDTH-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [BCD_W-1:0]     bcd_adj;

    // Add-3 correction on every digit that is 5 or more
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= BCD_ADJ_LIMIT)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + BCD_ADJ_ADD;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    // One shift step per cycle while busy
    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = mag;
            bcd_next  = '0;
            cnt_next  = CNT_W'(INT_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            {bcd_next, bin_next} = {bcd_adj[BCD_W-2:0], bin_reg, 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign bcd  = bcd_reg;
    assign done = done_reg;

endmodule

### rtl/sidt_emit.sv
// Character emitter: skips leading zeros, emits sign and digits through
// an output register. Depends on sidt_pkg.
`timescale 1ns / 1ps

module sidt_emit
    import sidt_pkg::*;
#(
    parameter int NUM_DIGITS = 10
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  sidt_emit_ctl_t          ctl,
    input  logic [NUM_DIGITS*4-1:0] bcd,
    output sidt_emit_stat_t         stat,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata,   // [5:0] character, [7:6] zero
    output logic                    m_tlast    // final_char
);

    localparam int BCD_W = NUM_DIGITS * 4;
    localparam int CNT_W = $clog2(NUM_DIGITS + 1);

    sidt_emit_state_t   state_reg, state_next;
    logic [BCD_W-1:0]   dig_reg, dig_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic               ov_reg, ov_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;
    logic [3:0]         top_digit;
    logic               slot_free;
    logic               done;

    assign top_digit = dig_reg[BCD_W-1 -: 4];
    assign slot_free = !ov_reg || m_tready;

    // Sequencer and output register load
    always_comb
    begin
        state_next = state_reg;
        dig_next   = dig_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        ov_next    = ov_reg && !m_tready;
        done       = 1'b0;
        case (state_reg)
            EM_IDLE:
            begin
                if (ctl.start)
                begin
                    dig_next   = bcd;
                    cnt_next   = CNT_W'(NUM_DIGITS);
                    neg_next   = ctl.neg;
                    state_next = EM_SKIP;
                end
            end
            EM_SKIP:
            begin
                // drop one leading zero per cycle, keep at least one digit
                if (top_digit == 4'd0 && cnt_reg != CNT_W'(1))
                begin
                    dig_next = dig_reg << 4;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else if (neg_reg)
                    state_next = EM_SIGN;
                else
                    state_next = EM_DIGIT;
            end
            EM_SIGN:
            begin
                if (slot_free)
                begin
                    char_next  = CHAR_MINUS;
                    last_next  = 1'b0;
                    ov_next    = 1'b1;
                    state_next = EM_DIGIT;
                end
            end
            EM_DIGIT:
            begin
                if (slot_free)
                begin
                    char_next = CHAR_ZERO + {2'b00, top_digit};
                    last_next = (cnt_reg == CNT_W'(1));
                    ov_next   = 1'b1;
                    dig_next  = dig_reg << 4;
                    cnt_next  = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                        state_next = EM_DRAIN;
                end
            end
            EM_DRAIN:
            begin
                // final item leaves the output register
                if (slot_free)
                begin
                    done       = 1'b1;
                    state_next = EM_IDLE;
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EM_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign stat.busy = (state_reg != EM_IDLE);
    assign stat.done = done;
    assign m_tvalid  = ov_reg;
    assign m_tdata   = {2'b00, char_reg};
    assign m_tlast   = last_reg;

endmodule

### rtl/signed_int_to_decimal_text_top.sv
// Signed integer to decimal text: sequencer, magnitude and sign stage.
// Depends on sidt_pkg, sidt_dabble, sidt_emit and the defines header.
//
// Usage:
//   Input channel s_*: one item is a signed integer in s_tdata. The low
//   INT_WIDTH bits are used; wider settings sign-extend from bit 31.
//   Output channel m_*: one item per ASCII character, most significant
//   first, '-' ahead of negative numbers, no leading zeros; zero gives '0'.
//   m_tlast marks the last character of each number.
// Timing:
//   s_tready is high only while the block is idle. After an accept the
//   shift-and-add-3 converter works through all INT_WIDTH bits, the
//   emitter drops leading zeros at one digit per cycle, then puts out
//   one character per cycle while m_tready stays high. The next item is
//   accepted only after the last character of the previous number has
//   left the output register.
// Reset: clears the sequencers and the output valid; no item is pending.
// Stall: a held m_tready freezes the output register and the emitter;
// no character is lost or repeated.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_text_top_defines.svh"

module signed_int_to_decimal_text_top
    import sidt_pkg::*;
#(
    parameter int INT_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] number
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] character, [7:6] zero
    output logic        m_tlast    // final_char
);

    // Decimal digits of 2^(INT_WIDTH-1)
    localparam int NUM_DIGITS = ((INT_WIDTH - 1) * 30103) / 100000 + 1;

    sidt_state_t            state_reg, state_next;
    logic                   neg_reg, neg_next;
    logic [INT_WIDTH-1:0]   raw;
    logic [INT_WIDTH-1:0]   mag;
    logic                   accept;
    logic                   dab_done;
    logic [NUM_DIGITS*4-1:0] bcd;
    sidt_emit_ctl_t         emit_ctl;
    sidt_emit_stat_t        emit_stat;

    // Take the low INT_WIDTH bits, sign-extend for wide settings
    generate
        if (INT_WIDTH <= 32)
        begin : g_narrow
            assign raw = s_tdata[INT_WIDTH-1:0];
        end
        else
        begin : g_wide
            assign raw = {{(INT_WIDTH-32){s_tdata[31]}}, s_tdata};
        end
    endgenerate

    // Unsigned magnitude; the most negative value maps to 2^(INT_WIDTH-1)
    assign mag    = raw[INT_WIDTH-1] ? (~raw + INT_WIDTH'(1)) : raw;
    assign accept = s_tvalid && s_tready;

    // Item sequencer
    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    neg_next   = raw[INT_WIDTH-1];
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (dab_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_stat.done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
    end

    assign s_tready       = (state_reg == ST_IDLE);
    assign emit_ctl.start = dab_done;
    assign emit_ctl.neg   = neg_reg;

    sidt_dabble #(
        .INT_WIDTH  (INT_WIDTH),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .mag   (mag),
        .bcd   (bcd),
        .done  (dab_done)
    );

    sidt_emit #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (emit_ctl),
        .bcd      (bcd),
        .stat     (emit_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Checks
    `SIDT_ASSERT_SAME(a_idle_no_output, s_tready, !m_tvalid && !emit_stat.busy,
        "output active while accepting input")
    `SIDT_ASSERT_SAME(a_conv_done_in_conv, dab_done, state_reg == ST_CONV,
        "converter finished outside conversion")
    `SIDT_ASSERT_NEXT(a_last_frees_input, m_tvalid && m_tready && m_tlast, s_tready,
        "input not ready after last character")

endmodule
